### design/wbs_pkg.sv
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared constants and types for the wildcard byte pattern search.
// ----------------------------------------------------------------------------
package wbs_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 16;
   localparam int OFFSET_BITS_DEF       = 32;
   localparam int PATTERN_SLOTS         = 16;
   localparam int SLOT_W                = 4;
   localparam int LEN_W                 = 5;
   localparam int ADDR_W                = 64;
   localparam int CSR_DATA_W            = 64;
   localparam int CSR_INDEX_W           = 3;
   localparam int CARE_W                = 16;

   typedef logic [PATTERN_SLOTS-1:0][7:0] pattern_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_MASK    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_BASE_ADDRESS = 3'd4
   } csr_index_type;

endpackage

### design/wildcard_byte_pattern_search.sv
// A result word is registered in stage 1 (found flag, offset), then in stage 2.
// Throughput: one byte per cycle while req_stall is low; the cell chain shifts
// on each accepted byte and compares the full window; address add is stage 2.
// Reset (synchronous): clears configuration, byte count, match flag and the
// pipeline valid bits; window bytes are qualified by the byte count.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Scans a region byte by byte for the first match of a wildcard byte pattern.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search import wbs_pkg::*; #(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
   parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_region_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_found,
   output logic [ADDR_W-1:0]      rsp_match_address
);

   localparam logic [OFFSET_BITS-1:0] COUNT_LIMIT = '1;

   logic [63:0]             pat_low_ff, pat_high_ff, base_ff;
   logic [CARE_W-1:0]       care_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [OFFSET_BITS-1:0]  seen_ff, seen_in, seen_next;
   logic                    reported_ff, reported_in;
   logic                    s1_valid_ff, s1_found_ff;
   logic [OFFSET_BITS-1:0]  s1_offset_ff;
   logic                    rsp_valid_ff, rsp_found_ff;
   logic [ADDR_W-1:0]       rsp_addr_ff;
   logic                    accept, adv2, adv1, len_ok, seen_ok, match, emit;
   pattern_type             pattern;
   logic [MAX_PATTERN_BYTES-1:0]      hits;
   logic [MAX_PATTERN_BYTES:0][7:0]   chain;

   assign pattern = pattern_type'({pat_high_ff, pat_low_ff});

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
         len_ff      <= '0;
         base_ff     <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_write_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_write_data;
            CSR_CARE_MASK:    care_ff     <= csr_write_data[CARE_W-1:0];
            CSR_PATTERN_LEN:  len_ff      <= csr_write_data[LEN_W-1:0];
            CSR_BASE_ADDRESS: base_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // cell chain
   assign chain[0] = req_data_byte;

   for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
      wbs_cell #(
         .CELL_INDEX (k),
         .NUM_CELLS  (MAX_PATTERN_BYTES)
      ) u_cell (
         .clock          (clock),
         .shift          (accept),
         .byte_in        (chain[k]),
         .pattern        (pattern),
         .care_mask      (care_ff),
         .pattern_length (len_ff),
         .byte_out       (chain[k+1]),
         .hit            (hits[k])
      );
   end

   // handshake
   assign adv2      = !rsp_valid_ff || !rsp_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign accept    = req_valid && adv1;

   // scan control
   always_comb begin
      seen_next = (seen_ff == COUNT_LIMIT) ? seen_ff : seen_ff + OFFSET_BITS'(1);
      len_ok    = (len_ff != '0) && (len_ff <= LEN_W'(PATTERN_SLOTS)) &&
                  (32'(len_ff) <= 32'(MAX_PATTERN_BYTES));
      seen_ok   = seen_next >= OFFSET_BITS'(len_ff);
      match     = !reported_ff && len_ok && seen_ok && (&hits);
      emit      = match || (req_region_end && !reported_ff);
      seen_in     = req_region_end ? '0 : seen_next;
      reported_in = req_region_end ? 1'b0 : (reported_ff || match);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (accept) begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   // stage 1: found flag and offset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && accept && emit) begin
         s1_found_ff  <= match;
         s1_offset_ff <= seen_next - OFFSET_BITS'(len_ff);
      end
   end

   // stage 2: address add, output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv2) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         rsp_found_ff <= s1_found_ff;
         rsp_addr_ff  <= s1_found_ff ? base_ff + ADDR_W'(s1_offset_ff) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_address = rsp_addr_ff;

   // checks
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_address == '0)
      else $error("not-found word carries a nonzero address");

   a_region_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_region_end |=> seen_ff == '0 && !reported_ff)
      else $error("scan state not cleared after region end");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_region_end && seen_ff != COUNT_LIMIT
      |=> seen_ff == $past(seen_ff) + OFFSET_BITS'(1))
      else $error("byte count did not advance");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      accept && reported_ff |-> !match)
      else $error("second match reported in one region");

endmodule

### design/wbs_cell.sv
// ----------------------------------------------------------------------------
// wbs_cell
// One window cell: holds one byte, passes it on each shift, and checks the
// incoming byte against the pattern slot that lines up with its position.
// ----------------------------------------------------------------------------
module wbs_cell import wbs_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int NUM_CELLS  = MAX_PATTERN_BYTES_DEF
) (
   input  logic                clock,
   input  logic                shift,
   input  logic [7:0]          byte_in,
   input  pattern_type         pattern,
   input  logic [CARE_W-1:0]   care_mask,
   input  logic [LEN_W-1:0]    pattern_length,
   output logic [7:0]          byte_out,
   output logic                hit
);

   localparam int IW = $clog2(NUM_CELLS + PATTERN_SLOTS) + 1;

   logic [7:0]    byte_ff;
   logic [IW-1:0] diff;
   logic [SLOT_W-1:0] slot;
   logic          active;

   always_ff @(posedge clock) begin
      if (shift) begin
         byte_ff <= byte_in;
      end
   end

   // window position k lines up with pattern slot len-1-k
   always_comb begin
      active = IW'(pattern_length) > IW'(CELL_INDEX);
      diff   = IW'(pattern_length) - IW'(CELL_INDEX) - IW'(1);
      slot   = diff[SLOT_W-1:0];
      hit    = !active || !care_mask[slot] || (byte_in == pattern[slot]);
   end

   assign byte_out = byte_ff;

endmodule
